### hw/rtl/mrc_pkg.sv
// Shared constants, types and command structures of the MIP ray caster.
`timescale 1ns / 1ps
`default_nettype none
package mrc_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int FRAC        = 14;
    localparam int WGT_W       = FRAC + 1;
    localparam int POS_W       = 32;
    localparam int INT_W       = POS_W - FRAC;
    localparam int END_MARGIN  = 5;
    localparam int VAL_W       = 16;
    localparam int STEP_W      = 16;
    localparam int START_W     = 24;
    localparam int COORD_W     = 6;
    localparam int EXT_W       = 7;
    localparam int CFG_A_W     = 2;
    localparam int CFG_D_W     = 16;
    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_A_W-1:0] REG_VOL_WIDTH  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_VOL_LENGTH = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_VOL_HEIGHT = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_MAX_STEPS  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef struct packed {
        logic       write_vox;
        logic       load;
        logic       advance;
        logic       acc_clr;
        logic       issue;
        logic [2:0] corner;
        logic       take_max;
        logic       finish;
        logic       trunc;
    } t_dp_cmd;

    typedef struct packed {
        logic exit_ray;
        logic at_limit;
        logic in_vol;
    } t_dp_status;

endpackage
`default_nettype wire

### hw/rtl/mrc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module mrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/mrc_datapath.sv
// Position walker, trilinear sample pipeline, maximum and configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module mrc_datapath #(
    parameter int MAX_DIM = mrc_pkg::MAX_DIM_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mrc_pkg::t_dp_cmd              i_cmd,
    output mrc_pkg::t_dp_status                o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [mrc_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  wire logic [mrc_pkg::CFG_D_W-1:0]   i_cfg_data,
    input  wire logic [mrc_pkg::COORD_W-1:0]   i_vx,
    input  wire logic [mrc_pkg::COORD_W-1:0]   i_vy,
    input  wire logic [mrc_pkg::COORD_W-1:0]   i_vz,
    input  wire logic [mrc_pkg::VAL_W-1:0]     i_value,
    input  wire logic [mrc_pkg::START_W-1:0]   i_sx,
    input  wire logic [mrc_pkg::START_W-1:0]   i_sy,
    input  wire logic [mrc_pkg::START_W-1:0]   i_sz,
    input  wire logic [mrc_pkg::STEP_W-1:0]    i_dx,
    input  wire logic [mrc_pkg::STEP_W-1:0]    i_dy,
    input  wire logic [mrc_pkg::STEP_W-1:0]    i_dz,
    output logic      [mrc_pkg::VAL_W-1:0]     o_max,
    output logic                               o_trunc
);
    import mrc_pkg::*;

    localparam int AW     = $clog2(MAX_DIM);
    localparam int EXW    = AW + 1;
    localparam int ADDR_W = 3 * AW;
    localparam int M1_W   = VAL_W + WGT_W;
    localparam int WYZ_W  = 2 * WGT_W;
    localparam int M2_W   = M1_W + WYZ_W;
    localparam int ACC_W  = M2_W + 3;
    localparam int PAD_W  = POS_W - START_W - 2;

    logic [EXT_W-1:0]  r_vol_w, r_vol_l, r_vol_h;
    logic [STEP_W-1:0] r_max_steps;
    logic [STEP_W-1:0] r_steps;

    logic signed [POS_W-1:0]  r_px, r_py, r_pz;
    logic signed [STEP_W-1:0] r_dx, r_dy, r_dz;

    logic [VAL_W-1:0] r_best;
    logic [ACC_W-1:0] r_acc;

    logic             r_p1_vld, r_p1_ok;
    logic [WGT_W-1:0] r_p1_wx;
    logic [WYZ_W-1:0] r_p1_wyz;
    logic             r_p2_vld;
    logic [M1_W-1:0]  r_p2_m1;
    logic [WYZ_W-1:0] r_p2_wyz;
    logic             r_p3_vld;
    logic [M2_W-1:0]  r_p3_m2;

    logic [EXW-1:0]   ew, el, eh;
    logic [INT_W-1:0] ix, iy, iz;
    logic [EXW-1:0]   cx, cy, cz;
    logic [WGT_W-1:0] wx, wy, wz;
    logic             ok;
    logic signed [INT_W:0] y_rel;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [VAL_W-1:0]  rdata;
    logic              wr_ok;
    logic [VAL_W-1:0]  sample;

    assign ew = (32'(r_vol_w) > 32'(MAX_DIM)) ? EXW'(MAX_DIM) : EXW'(r_vol_w);
    assign el = (32'(r_vol_l) > 32'(MAX_DIM)) ? EXW'(MAX_DIM) : EXW'(r_vol_l);
    assign eh = (32'(r_vol_h) > 32'(MAX_DIM)) ? EXW'(MAX_DIM) : EXW'(r_vol_h);

    assign ix = r_px[POS_W-1:FRAC];
    assign iy = r_py[POS_W-1:FRAC];
    assign iz = r_pz[POS_W-1:FRAC];

    assign y_rel = $signed({iy[INT_W-1], iy}) + $signed((INT_W+1)'(r_vol_l))
                 + $signed((INT_W+1)'(END_MARGIN));

    assign o_status.exit_ray = y_rel[INT_W];
    assign o_status.at_limit = (r_steps >= r_max_steps);
    assign o_status.in_vol =
        !r_px[POS_W-1] && (r_px != '0) && (ix < INT_W'(ew)) &&
        !r_py[POS_W-1] && (r_py != '0) && (iy < INT_W'(el)) &&
        !r_pz[POS_W-1] && (r_pz != '0) && (iz < INT_W'(eh));

    assign cx = {1'b0, ix[AW-1:0]} + EXW'(i_cmd.corner[0]);
    assign cy = {1'b0, iy[AW-1:0]} + EXW'(i_cmd.corner[1]);
    assign cz = {1'b0, iz[AW-1:0]} + EXW'(i_cmd.corner[2]);
    assign ok = (cx < ew) && (cy < el) && (cz < eh);

    assign wx = i_cmd.corner[0] ? {1'b0, r_px[FRAC-1:0]}
                                : WGT_W'(1 << FRAC) - {1'b0, r_px[FRAC-1:0]};
    assign wy = i_cmd.corner[1] ? {1'b0, r_py[FRAC-1:0]}
                                : WGT_W'(1 << FRAC) - {1'b0, r_py[FRAC-1:0]};
    assign wz = i_cmd.corner[2] ? {1'b0, r_pz[FRAC-1:0]}
                                : WGT_W'(1 << FRAC) - {1'b0, r_pz[FRAC-1:0]};

    assign raddr = {cz[AW-1:0], cy[AW-1:0], cx[AW-1:0]};
    assign waddr = {AW'(i_vz), AW'(i_vy), AW'(i_vx)};
    assign wr_ok = i_cmd.write_vox && (32'(i_vx) < 32'(MAX_DIM))
                 && (32'(i_vy) < 32'(MAX_DIM)) && (32'(i_vz) < 32'(MAX_DIM));

    assign sample = r_acc[3*FRAC +: VAL_W];

    mrc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (1 << ADDR_W)
    ) u_vol (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_w     <= EXT_W'(64);
            r_vol_l     <= EXT_W'(64);
            r_vol_h     <= EXT_W'(64);
            r_max_steps <= STEP_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VOL_WIDTH:  r_vol_w     <= i_cfg_data[EXT_W-1:0];
                REG_VOL_LENGTH: r_vol_l     <= i_cfg_data[EXT_W-1:0];
                REG_VOL_HEIGHT: r_vol_h     <= i_cfg_data[EXT_W-1:0];
                REG_MAX_STEPS:  r_max_steps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_ok  <= ok;
        r_p1_wx  <= wx;
        r_p1_wyz <= WYZ_W'(wy) * WYZ_W'(wz);
        r_p2_m1  <= r_p1_ok ? M1_W'(rdata) * M1_W'(r_p1_wx) : '0;
        r_p2_wyz <= r_p1_wyz;
        r_p3_m2  <= M2_W'(r_p2_m1) * M2_W'(r_p2_wyz);

        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_p3_vld) begin
            r_acc <= r_acc + ACC_W'(r_p3_m2);
        end

        if (i_cmd.load) begin
            r_px    <= {{PAD_W{i_sx[START_W-1]}}, i_sx, 2'b00};
            r_py    <= {{PAD_W{i_sy[START_W-1]}}, i_sy, 2'b00};
            r_pz    <= {{PAD_W{i_sz[START_W-1]}}, i_sz, 2'b00};
            r_dx    <= i_dx;
            r_dy    <= i_dy;
            r_dz    <= i_dz;
            r_steps <= '0;
            r_best  <= '0;
        end else begin
            if (i_cmd.take_max && (sample > r_best)) begin
                r_best <= sample;
            end
            if (i_cmd.advance) begin
                r_px    <= r_px + POS_W'(r_dx);
                r_py    <= r_py + POS_W'(r_dy);
                r_pz    <= r_pz + POS_W'(r_dz);
                r_steps <= r_steps + 1'b1;
            end
        end

        if (i_cmd.finish) begin
            o_max   <= r_best;
            o_trunc <= i_cmd.trunc;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mrc_ctrl.sv
// Controller state machine: item intake, march sequencing and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module mrc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_op,
    output logic                     o_s_tready,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire mrc_pkg::t_dp_status i_status,
    output mrc_pkg::t_dp_cmd         o_cmd
);
    import mrc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_ISSUE  = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_UPDATE = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    localparam logic [2:0] LAST_CORNER = 3'd7;
    localparam logic [2:0] LAST_DRAIN  = 3'd2;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_trunc, n_trunc;
    logic       r_out_vld, n_out_vld;
    logic       out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign out_free   = !r_out_vld || i_m_tready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_trunc   = r_trunc;
        n_out_vld = (r_out_vld && !i_m_tready);
        o_cmd     = '0;
        o_cmd.corner = r_cnt;
        o_cmd.trunc  = r_trunc;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_op == OP_CAST) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CHECK;
                    end else begin
                        o_cmd.write_vox = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.exit_ray) begin
                    n_trunc = 1'b0;
                    n_state = S_FINISH;
                end else if (i_status.at_limit) begin
                    n_trunc = 1'b1;
                    n_state = S_FINISH;
                end else if (i_status.in_vol) begin
                    o_cmd.acc_clr = 1'b1;
                    n_cnt   = '0;
                    n_state = S_ISSUE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CORNER) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_DRAIN) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.take_max = 1'b1;
                o_cmd.advance  = 1'b1;
                n_state = S_CHECK;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_trunc   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_trunc   <= n_trunc;
            r_out_vld <= n_out_vld;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mip_ray_caster_trilinear.sv
// Top level of the maximum intensity projection ray caster with trilinear sampling.
//
// Input stream: each item is a voxel write (tuser = 0) or a ray cast (tuser = 1).
// A write stores one 16-bit voxel while the block stays idle; it gives no result.
// A cast loads start point and step, then marches: a step outside the volume is a
// check and an advance, a step strictly inside is a check, eight corner reads through
// the single read port of the volume memory, a drain of the multiply chain pipeline
// and a maximum update with the advance. The march ends in the finish state, which
// registers the result once the output register is free.
// The block takes one item at a time; tready is high only while idle.
// Output stream: max_intensity in tdata, ray_truncated in tuser; the result is
// held in an output register, so a stalled receiver only blocks the end of the
// next cast, while writes are still taken.
// Configuration: write enable, index, data; write only while idle.
// Reset clears the configuration registers to 64, 64, 64, 4096 and drops any
// pending result; the volume memory is not cleared and must be written first.
`timescale 1ns / 1ps
`default_nettype none
module mip_ray_caster_trilinear #(
    parameter int MAX_DIM = mrc_pkg::MAX_DIM_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // voxel_x, voxel_y, voxel_z, voxel_value, start_x, start_y, start_z,
    // step_x, step_y, step_z, zero fill
    input  wire logic [mrc_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // operation
    input  wire logic                             i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // max_intensity
    output logic      [mrc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // ray_truncated
    output logic                                  o_m_tuser,
    input  wire logic                             i_cfg_we,
    input  wire logic [mrc_pkg::CFG_A_W-1:0]      i_cfg_addr,
    input  wire logic [mrc_pkg::CFG_D_W-1:0]      i_cfg_data
);
    import mrc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    mrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mrc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_vx       (i_s_tdata[5:0]),
        .i_vy       (i_s_tdata[11:6]),
        .i_vz       (i_s_tdata[17:12]),
        .i_value    (i_s_tdata[33:18]),
        .i_sx       (i_s_tdata[57:34]),
        .i_sy       (i_s_tdata[81:58]),
        .i_sz       (i_s_tdata[105:82]),
        .i_dx       (i_s_tdata[121:106]),
        .i_dy       (i_s_tdata[137:122]),
        .i_dz       (i_s_tdata[153:138]),
        .o_max      (o_m_tdata),
        .o_trunc    (o_m_tuser)
    );
endmodule
`default_nettype wire

### hw/rtl/mrc_checker.sv
// Port-level checker for the ray caster and its bind.
`timescale 1ns / 1ps
`default_nettype none
module mrc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic                            i_s_tuser,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [mrc_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input wire logic                            o_m_tuser
);
    import mrc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result item changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_CAST) |=> !o_s_tready)
        else $error("new item taken during a cast");
endmodule

bind mip_ray_caster_trilinear mrc_checker u_mrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

### test/mip_ray_caster_trilinear_tb.sv
// Testbench of the MIP ray caster: fills the volume, casts rays and checks each result.
`timescale 1ns / 1ps
module mip_ray_caster_trilinear_tb;
    import mrc_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_A_W-1:0]    cfg_addr = '0;
    logic [CFG_D_W-1:0]    cfg_data = '0;

    mip_ray_caster_trilinear i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    always #4 i_clk = ~i_clk;

    bit [15:0] vol_mem [0:262143];
    int unsigned vol_w = 64, vol_l = 64, vol_h = 64, step_limit = 4096;
    bit [16:0] expected_q [$];
    int unsigned errors = 0;
    int unsigned burst_left = 0;

    function automatic logic [IN_DATA_W-1:0] pack_item(
        input logic [5:0] vx, vy, vz, input logic [15:0] val,
        input logic [23:0] sx, sy, sz, input logic [15:0] dx, dy, dz);
        return {6'b0, dz, dy, dx, sz, sy, sx, val, vz, vy, vx};
    endfunction

    function automatic longint unsigned voxel_at(input longint x, y, z,
                                                 input int unsigned ew, el, eh);
        if (x < 0 || y < 0 || z < 0) return 0;
        if (x >= ew || y >= el || z >= eh) return 0;
        return vol_mem[x + 64 * (y + 64 * z)];
    endfunction

    function automatic bit [15:0] trilinear(input longint px, py, pz,
                                            input int unsigned ew, el, eh);
        longint xl, yl, zl;
        longint unsigned fx, fy, fz, wx, wy, wz, sum;
        sum = 0;
        xl = px >>> FRAC; yl = py >>> FRAC; zl = pz >>> FRAC;
        fx = px & 16383; fy = py & 16383; fz = pz & 16383;
        for (int c = 0; c < 8; c++) begin
            wx = c[0] ? fx : 16384 - fx;
            wy = c[1] ? fy : 16384 - fy;
            wz = c[2] ? fz : 16384 - fz;
            sum += voxel_at(xl + c[0], yl + c[1], zl + c[2], ew, el, eh) * (wx * wy * wz);
        end
        return sum[57:42];
    endfunction

    // returns {truncated, max_intensity}
    function automatic bit [16:0] project_ray(input logic [IN_DATA_W-1:0] d);
        longint x, y, z, dx, dy, dz, yend;
        int unsigned ew, el, eh, steps;
        bit [15:0] best, s;
        bit tr;
        ew = vol_w > 64 ? 64 : vol_w;
        el = vol_l > 64 ? 64 : vol_l;
        eh = vol_h > 64 ? 64 : vol_h;
        x = $signed(d[57:34]);   x = x * 4;
        y = $signed(d[81:58]);   y = y * 4;
        z = $signed(d[105:82]);  z = z * 4;
        dx = $signed(d[121:106]);
        dy = $signed(d[137:122]);
        dz = $signed(d[153:138]);
        yend = -(longint'(vol_l) + END_MARGIN) * 16384;
        best = 0; steps = 0; tr = 0;
        while (y >= yend) begin
            if (steps >= step_limit) begin
                tr = 1;
                break;
            end
            if (x > 0 && x < ew * 16384 && y > 0 && y < el * 16384
                    && z > 0 && z < eh * 16384) begin
                s = trilinear(x, y, z, ew, el, eh);
                if (s > best) best = s;
            end
            x += dx; y += dy; z += dz;
            steps++;
        end
        return {tr, best};
    endfunction

    task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = d;
        do @(posedge i_clk); while (!s_tready);
        if (op == OP_CAST)
            expected_q.push_back(project_ray(d));
        else
            vol_mem[d[5:0] + 64 * (d[11:6] + 64 * d[17:12])] = d[33:18];
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int unsigned val);
        wait (expected_q.size() == 0);
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we = 1'b1; cfg_addr = idx; cfg_data = CFG_D_W'(val);
        case (idx)
            REG_VOL_WIDTH:  vol_w = val;
            REG_VOL_LENGTH: vol_l = val;
            REG_VOL_HEIGHT: vol_h = val;
            REG_MAX_STEPS:  step_limit = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_volume(input int unsigned w, l, h, ms);
        write_reg(REG_VOL_WIDTH, w);
        write_reg(REG_VOL_LENGTH, l);
        write_reg(REG_VOL_HEIGHT, h);
        write_reg(REG_MAX_STEPS, ms);
    endtask

    task automatic write_voxel(input int unsigned x, y, z, input logic [15:0] val);
        send_item(OP_WRITE, pack_item(6'(x), 6'(y), 6'(z), val,
                                      24'($urandom), 24'($urandom), 24'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    task automatic fill_region();
        for (int z = 0; z < vol_h; z++)
            for (int y = 0; y < vol_l; y++)
                for (int x = 0; x < vol_w; x++)
                    write_voxel(x, y, z, 16'($urandom));
    endtask

    task automatic cast_ray(input int sx, sy, sz, dx, dy, dz);
        send_item(OP_CAST, pack_item(6'($urandom), 6'($urandom), 6'($urandom),
                                     16'($urandom), 24'(sx), 24'(sy), 24'(sz),
                                     16'(dx), 16'(dy), 16'(dz)));
    endtask

    task automatic test_directed();
        set_volume(4, 4, 4, 400);
        fill_region();
        write_voxel(1, 1, 1, 16'hFFFF);
        write_voxel(2, 1, 1, 16'h0000);
        write_voxel(63, 63, 63, 16'hFFFF);
        cast_ray(4096, 4 * 4096, 4096, 0, -16384, 0);
        cast_ray(6144, 20000, 6000, 1000, -4096, 700);
        cast_ray(8388607, 8388607, 8388607, 16384, -16384, -16384);
        cast_ray(-8388608, -8388608, -8388608, -16384, 16384, 16384);
        cast_ray(-9 * 4096 - 100, -9 * 4096 - 1, 0, 0, 0, 0);
        cast_ray(4096, 8192, 4096, 0, 16384, 0);
        cast_ray(4096, 8192, 4096, 0, 0, 0);
        cast_ray(0, 8192, 0, 0, -16384, 0);
        write_reg(REG_MAX_STEPS, 1);
        cast_ray(6144, 6144, 6144, 0, -16384, 0);
        cast_ray(6144, -9 * 4096, 6144, 0, -16384, 0);
        write_reg(REG_MAX_STEPS, 65535);
        cast_ray(-4096, 0, 0, 0, 0, 0);
        cast_ray(6144, 5 * 4096, 6144, 500, -16384, -300);
    endtask

    task automatic test_random(input int unsigned w, l, h, ms, n);
        int unsigned r;
        set_volume(w, l, h, ms);
        fill_region();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                cast_ray($urandom_range(0, w * 4096), l * 4096 + $urandom_range(0, 4096),
                         $urandom_range(0, h * 4096), int'($urandom_range(0, 8192)) - 4096,
                         -int'($urandom_range(2048, 16384)),
                         int'($urandom_range(0, 8192)) - 4096);
            else if (r < 75)
                write_voxel($urandom_range(0, w - 1), $urandom_range(0, l - 1),
                            $urandom_range(0, h - 1), 16'($urandom));
            else if (r < 85)
                write_voxel($urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 63), 16'($urandom));
            else
                cast_ray($urandom, $urandom, $urandom, int'($urandom_range(0, 32768)) - 16384,
                         int'($urandom_range(0, 32768)) - 16384,
                         int'($urandom_range(0, 32768)) - 16384);
        end
    endtask

    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: m_tready = 1'b1;
            1: m_tready = ($urandom_range(0, 3) != 0);
            default: m_tready = ((rx_cycle % 9) < 4);
        endcase
    end

    always @(posedge i_clk) begin
        bit [16:0] exp_res;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h/%b", m_tdata, m_tuser);
            end else begin
                exp_res = expected_q.pop_front();
                if (m_tdata !== exp_res[15:0] || m_tuser !== exp_res[16]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h/%b actual %h/%b",
                                 exp_res[15:0], exp_res[16], m_tdata, m_tuser);
                end
            end
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(4, 4, 4, 400, 20);
        test_random(64, 1, 1, 600, 15);
        test_random(1, 16, 1, 600, 10);
        test_random(3, 2, 2, 4096, 10);
        wait (expected_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("** mip_ray_caster_trilinear: PASSED **");
        else
            $display("** mip_ray_caster_trilinear: FAILED **");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("** mip_ray_caster_trilinear: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_ram.sv
hw/rtl/mrc_datapath.sv
hw/rtl/mrc_ctrl.sv
hw/rtl/mip_ray_caster_trilinear.sv
hw/rtl/mrc_checker.sv
test/mip_ray_caster_trilinear_tb.sv
